FILE: rtl/phw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the pre-emphasis and Hamming window block.
// Used by phw_ctrl, phw_datapath and the top level; depends on nothing.
package phw_pkg;

    // Field and register widths.
    localparam int SampleW = 16;
    localparam int CoeffW  = 16;
    localparam int RecipW  = 17;
    localparam int ResultW = 35;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 17;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgWindowMode  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgPreemphCoef = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgNormRecip   = 2'd2;

    // Register reset values.
    localparam logic              ResetWindowMode = 1'b1;
    localparam logic [CoeffW-1:0] ResetPreemph    = 16'd31130;
    localparam logic [RecipW-1:0] ResetNormRecip  = 17'd65536;

    // Unity gain of the window in Q1.15.
    localparam logic [16:0] WinOne = 17'd32768;

    // Fixed-point constants used to build the window table.
    localparam logic [63:0] OneQ30    = 64'd1 << 30;
    localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
    localparam int          SeriesTerms = 12;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a request, update frame state, read the window table
        logic pe_en;     // form the pre-emphasized value and select the window gain
        logic win_en;    // multiply by the window gain
        logic round_en;  // round to 16 fractional bits
        logic norm_en;   // multiply by the normalizing reciprocal
        logic out_load;  // round and load the output register
    } t_dp_cmd;

endpackage

FILE: rtl/phw_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine and handshake control for the window block.
// Depends on phw_pkg for the datapath command struct.
module phw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output phw_pkg::t_dp_cmd o_cmd
);
    import phw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PE,
        S_WIN,
        S_ROUND,
        S_NORM,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    // The output slot can take a new result when empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    // Command decode from the current state.
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = o_in_ready && i_in_valid;
        o_cmd.pe_en    = (r_state == S_PE);
        o_cmd.win_en   = (r_state == S_WIN);
        o_cmd.round_en = (r_state == S_ROUND);
        o_cmd.norm_en  = (r_state == S_NORM);
        o_cmd.out_load = (r_state == S_DONE) && out_free;
    end

    // No request is taken while reset is held.
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    // State register and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_PE;
                S_PE:    r_state <= S_WIN;
                S_WIN:   r_state <= S_ROUND;
                S_ROUND: r_state <= S_NORM;
                S_NORM:  r_state <= S_DONE;
                S_DONE:  if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A new result appears only when the sequence finishes.
    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("output valid rose outside the final step");

    // An accepted request runs the four arithmetic steps in order.
    a_step_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##3 (r_state == S_NORM))
        else $error("arithmetic steps out of order");

    // A stalled result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.out_load)
        else $error("result overwritten while stalled");

    // The final step waits while the receiver stalls.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("final step left while output blocked");

endmodule

FILE: rtl/phw_datapath.sv
`timescale 1ns / 1ps
// Arithmetic datapath, frame state, configuration registers and window ROM.
// Depends on phw_pkg; driven by the command struct from phw_ctrl.
module phw_datapath #(
    parameter int FRAME_LEN = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  phw_pkg::t_dp_cmd                 i_cmd,
    input  logic                             i_cfg_we,
    input  logic [phw_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [phw_pkg::CfgW-1:0]         i_cfg_data,
    input  logic signed [phw_pkg::SampleW-1:0] i_sample,
    output logic signed [phw_pkg::ResultW-1:0] o_windowed_value,
    output logic                             o_last_of_frame
);
    import phw_pkg::*;

    localparam int PosW = $clog2(FRAME_LEN);
    localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LEN - 1);

    typedef logic [15:0] t_rom [FRAME_LEN];

    // Unsigned restoring division, used only while the window table is built.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor series in Q2.30 around zero; fd is the first factorial factor.
    function automatic longint series_q30(logic [63:0] a, logic [63:0] start,
                                          logic [63:0] fd);
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] d0;
        logic [63:0] den;
        longint      sum;
        a2   = (a * a + (64'd1 << 29)) >> 30;
        term = start;
        sum  = longint'(start);
        for (int k = 0; k < SeriesTerms; k++) begin
            d0   = fd + 64'(2 * k);
            den  = (d0 * (d0 + 64'd1)) << 30;
            term = udiv64(term * a2 + (den >> 1), den);
            if (k[0]) begin
                sum = sum + longint'(term);
            end else begin
                sum = sum - longint'(term);
            end
        end
        return sum;
    endfunction

    // Hamming coefficient in Q1.15 for position n, cosine by quadrant.
    function automatic logic [15:0] hamming_q15(int n);
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] w;
        longint      c;
        longint      num;
        m = 64'(FRAME_LEN - 1);
        q = udiv64(64'(4 * n), m);
        r = 64'(4 * n) - q * m;
        a = udiv64(HalfPiQ30 * r + (m >> 1), m);
        case (q)
            64'd0:   c = series_q30(a, OneQ30, 64'd1);
            64'd1:   c = -series_q30(a, a, 64'd2);
            64'd2:   c = -series_q30(a, OneQ30, 64'd1);
            64'd3:   c = series_q30(a, a, 64'd2);
            default: c = longint'(OneQ30);
        endcase
        num = 54 * longint'(OneQ30) - 46 * c;
        if (num < 0) begin
            num = 0;
        end
        w = udiv64(64'(num) + (64'd100 << 14), 64'd100 << 15);
        if (w > 64'd32768) begin
            w = 64'd32768;
        end
        return w[15:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < FRAME_LEN; i++) begin
            rom[i] = hamming_q15(i);
        end
        return rom;
    endfunction

    localparam t_rom WinRom = build_rom();

    // Configuration and frame state.
    logic                      r_mode;
    logic [CoeffW-1:0]         r_coeff;
    logic [RecipW-1:0]         r_norm;
    logic signed [SampleW-1:0] r_prev;
    logic [PosW-1:0]           r_pos;

    // Working registers of the current request.
    logic signed [SampleW-1:0] r_x;
    logic                      r_first;
    logic                      r_last;
    logic [15:0]               r_coef;
    logic signed [32:0]        r_pprod;
    logic signed [32:0]        r_pe;
    logic [16:0]               r_w;
    logic signed [50:0]        r_p1;
    logic signed [33:0]        r_t;
    logic signed [51:0]        r_p2;
    logic signed [ResultW-1:0] r_y;
    logic                      r_last_out;

    logic signed [32:0] n_pprod;
    logic signed [32:0] n_pe;
    logic signed [50:0] n_p1;
    logic signed [50:0] n_sum1;
    logic signed [51:0] n_p2;
    logic signed [51:0] n_sum2;
    logic               pos_last;

    assign pos_last = (r_pos == LastPos);

    // Arithmetic for each step; a register follows every multiply.
    always_comb begin
        n_pprod = $signed({1'b0, r_coeff}) * r_prev;
        n_pe    = $signed({{2{r_x[SampleW-1]}}, r_x, 15'd0})
                  - (r_first ? 33'sd0 : r_pprod);
        n_p1    = r_pe * $signed({1'b0, r_w});
        n_sum1  = r_p1 + 51'sd8192;
        n_p2    = r_t * $signed({1'b0, r_norm});
        n_sum2  = r_p2 + 52'sd32768;
    end

    // Configuration writes and frame state, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ResetWindowMode;
            r_coeff <= ResetPreemph;
            r_norm  <= ResetNormRecip;
            r_prev  <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CfgWindowMode:  r_mode  <= i_cfg_data[0];
                    CfgPreemphCoef: r_coeff <= i_cfg_data[CoeffW-1:0];
                    CfgNormRecip:   r_norm  <= i_cfg_data[RecipW-1:0];
                    default:        ;
                endcase
            end
            if (i_cmd.load) begin
                r_prev <= i_sample;
                r_pos  <= pos_last ? '0 : r_pos + 1'b1;
            end
        end
    end

    // Payload registers of the step sequence.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= i_sample;
            r_first <= (r_pos == '0);
            r_last  <= pos_last;
            r_coef  <= WinRom[r_pos];
            r_pprod <= n_pprod;
        end
        if (i_cmd.pe_en) begin
            r_pe <= n_pe;
            r_w  <= r_mode ? {1'b0, r_coef} : WinOne;
        end
        if (i_cmd.win_en) begin
            r_p1 <= n_p1;
        end
        if (i_cmd.round_en) begin
            r_t <= n_sum1[47:14];
        end
        if (i_cmd.norm_en) begin
            r_p2 <= n_p2;
        end
        if (i_cmd.out_load) begin
            r_y        <= n_sum2[50:16];
            r_last_out <= r_last;
        end
    end

    assign o_windowed_value = r_y;
    assign o_last_of_frame  = r_last_out;

endmodule

FILE: rtl/preemphasis_hamming_window.sv
`timescale 1ns / 1ps
// Pre-emphasis and Hamming window front end: top level.
// Joins phw_ctrl and phw_datapath; depends on phw_pkg.
//
// The input channel (i_in_valid, o_in_ready) carries one signed 16-bit sample
// per request; the output channel (o_out_valid, i_out_ready) returns one
// 35-bit value with 16 fractional bits and a last-of-frame flag per sample.
// Frames are FRAME_LEN samples long; the first sample of a frame skips
// pre-emphasis. i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 window mode, 1 pre-emphasis coefficient, 2 normalizing reciprocal)
// at once; write only while the block is idle.
// A request is taken only while the sequencer is idle, so the next one is
// accepted only after the last result is loaded into the output register.
// Pre-emphasis, window multiply, rounding, normalizing multiply and output
// rounding run in order as a sequence of steps through one set of registers.
// If the receiver stalls, the finished value holds in the output register;
// a new request is still taken and runs until its output step, which waits
// for the output register to drain.
// Synchronous reset restores the register defaults, clears the previous
// sample and returns to the start of a frame; no request is taken during
// reset. The window table is a constant ROM and needs no fill.
module preemphasis_hamming_window #(
    parameter int FRAME_LEN = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [phw_pkg::SampleW-1:0]  i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [phw_pkg::ResultW-1:0]  o_windowed_value,
    output logic                                o_last_of_frame,
    input  logic                                i_cfg_we,
    input  logic [phw_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [phw_pkg::CfgW-1:0]            i_cfg_data
);
    import phw_pkg::*;

    t_dp_cmd cmd;

    // Sequencer and handshake control.
    phw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Arithmetic, frame state and configuration.
    phw_datapath #(
        .FRAME_LEN (FRAME_LEN)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample         (i_sample),
        .o_windowed_value (o_windowed_value),
        .o_last_of_frame  (o_last_of_frame)
    );

endmodule
